[hdl/lcs_pkg.sv]
// Shared types, codes and the microprogram of the linear contrast stretch unit.
package lcs_pkg;

    localparam int PIX_W  = 8;
    localparam int KIND_W = 2;
    localparam int UPC_W  = 4;
    localparam int CNT_W  = 3;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRETCH = 2'd2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_MEASURE,
        OP_LOAD,
        OP_DIV,
        OP_PUSH
    } t_op;

    // next-step selection
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_ACCEPT,
        JC_KIND,
        JC_BYPASS,
        JC_LOOP,
        JC_WAIT_OUT
    } t_jc;

    typedef struct packed {
        logic             in_rdy;
        t_op              op;
        t_jc              jc;
        logic [UPC_W-1:0] target;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        logic in_rdy;
        t_op  op;
    } t_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic              accept;
        logic [KIND_W-1:0] kind;
        logic              bypass;
        logic              cnt_zero;
        logic              out_free;
    } t_stat;

    localparam logic [UPC_W-1:0] U_FETCH   = 4'd0;
    localparam logic [UPC_W-1:0] U_DISP    = 4'd1;
    localparam logic [UPC_W-1:0] U_KBASE   = 4'd2;
    localparam logic [UPC_W-1:0] U_STRETCH = 4'd4;
    localparam logic [UPC_W-1:0] U_CHECK   = 4'd6;
    localparam logic [UPC_W-1:0] U_DIV     = 4'd7;
    localparam logic [UPC_W-1:0] U_PUSH    = 4'd8;

    // Microprogram ROM. Dispatch lands on U_KBASE + kind.
    function automatic t_uword urom(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS, target: U_FETCH};
        case (upc)
            4'd0: w = '{in_rdy: 1'b1, op: OP_NONE,    jc: JC_ACCEPT,   target: U_FETCH};
            4'd1: w = '{in_rdy: 1'b0, op: OP_NONE,    jc: JC_KIND,     target: U_KBASE};
            4'd2: w = '{in_rdy: 1'b0, op: OP_CLEAR,   jc: JC_ALWAYS,   target: U_FETCH};
            4'd3: w = '{in_rdy: 1'b0, op: OP_MEASURE, jc: JC_ALWAYS,   target: U_FETCH};
            4'd4: w = '{in_rdy: 1'b0, op: OP_LOAD,    jc: JC_ALWAYS,   target: U_CHECK};
            4'd5: w = '{in_rdy: 1'b0, op: OP_NONE,    jc: JC_ALWAYS,   target: U_FETCH};
            4'd6: w = '{in_rdy: 1'b0, op: OP_NONE,    jc: JC_BYPASS,   target: U_PUSH};
            4'd7: w = '{in_rdy: 1'b0, op: OP_DIV,     jc: JC_LOOP,     target: U_DIV};
            4'd8: w = '{in_rdy: 1'b0, op: OP_PUSH,    jc: JC_WAIT_OUT, target: U_FETCH};
            default: w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS,   target: U_FETCH};
        endcase
        return w;
    endfunction

endpackage

[hdl/lcs_useq.sv]
// Microcode sequencer: step counter, control ROM and jump logic.
module lcs_useq
    import lcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    logic [UPC_W-1:0] w_inc;
    t_uword           w_uw;

    assign w_uw  = urom(r_upc);
    assign w_inc = r_upc + 1'b1;

    assign o_ctrl.in_rdy = w_uw.in_rdy;
    assign o_ctrl.op     = w_uw.op;

    always_comb begin
        case (w_uw.jc)
            JC_NEXT:     n_upc = w_inc;
            JC_ALWAYS:   n_upc = w_uw.target;
            JC_ACCEPT:   n_upc = i_stat.accept ? w_inc : r_upc;
            JC_KIND:     n_upc = w_uw.target + {{(UPC_W-KIND_W){1'b0}}, i_stat.kind};
            JC_BYPASS:   n_upc = i_stat.bypass ? w_uw.target : w_inc;
            JC_LOOP:     n_upc = i_stat.cnt_zero ? w_inc : w_uw.target;
            JC_WAIT_OUT: n_upc = i_stat.out_free ? w_uw.target : r_upc;
            default:     n_upc = U_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[hdl/lcs_datapath.sv]
// Datapath: item register, running statistics, restoring divider, output register.
module lcs_datapath
    import lcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_s_tvalid,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_last,
    input  logic              i_m_tready,
    output t_stat             o_stat,
    output logic              o_m_tvalid,
    output logic [PIX_W-1:0]  o_stretched,
    output logic              o_last_out
);

    logic [KIND_W-1:0]  r_kind;
    logic [PIX_W-1:0]   r_pix;
    logic               r_last;
    logic [PIX_W-1:0]   r_min;
    logic [PIX_W-1:0]   r_max;
    logic [PIX_W:0]     r_rem;   // partial remainder, below divisor
    logic [PIX_W:0]     r_dvs;   // 2*(max-min)
    logic [PIX_W-1:0]   r_dlo;   // dividend bits still to shift in
    logic [PIX_W-1:0]   r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_byp;
    logic               r_out_vld;
    logic [PIX_W-1:0]   r_out_pix;
    logic               r_out_last;

    logic               w_accept;
    logic               w_out_free;
    logic [PIX_W-1:0]   w_diff;
    logic [PIX_W-1:0]   w_den;
    logic [2*PIX_W-1:0] w_num;
    logic [2*PIX_W:0]   w_dvd;
    logic               w_flat;
    logic               w_low;
    logic               w_high;
    logic [PIX_W+1:0]   w_shift;
    logic [PIX_W+1:0]   w_sub;
    logic               w_qbit;

    assign w_accept   = i_s_tvalid && i_ctrl.in_rdy;
    assign w_out_free = !r_out_vld || i_m_tready;

    assign w_flat = (r_min >= r_max);
    assign w_low  = (r_pix <= r_min);
    assign w_high = (r_pix >= r_max);
    assign w_diff = r_pix - r_min;
    assign w_den  = r_max - r_min;
    // 255*d = 256*d - d; dividend = 2*num + den for round half up
    assign w_num  = {w_diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, w_diff};
    assign w_dvd  = {w_num, 1'b0} + {{(PIX_W+1){1'b0}}, w_den};

    assign w_shift = {r_rem, r_dlo[PIX_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dvs};
    assign w_qbit  = (w_shift >= {1'b0, r_dvs});

    assign o_stat.accept   = w_accept;
    assign o_stat.kind     = r_kind;
    assign o_stat.bypass   = r_byp;
    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.out_free = w_out_free;

    assign o_m_tvalid  = r_out_vld;
    assign o_stretched = r_out_pix;
    assign o_last_out  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= PIX_MAX;
            r_max     <= PIX_MIN;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_kind <= i_kind;
                r_pix  <= i_pixel;
                r_last <= i_last;
            end
            case (i_ctrl.op)
                OP_CLEAR: begin
                    r_min <= PIX_MAX;
                    r_max <= PIX_MIN;
                end
                OP_MEASURE: begin
                    if (r_pix < r_min) begin
                        r_min <= r_pix;
                    end
                    if (r_pix > r_max) begin
                        r_max <= r_pix;
                    end
                end
                OP_LOAD: begin
                    r_byp <= w_flat || w_low || w_high;
                    if (w_flat) begin
                        r_quot <= r_pix;
                    end else if (w_low) begin
                        r_quot <= PIX_MIN;
                    end else begin
                        r_quot <= PIX_MAX;
                    end
                    // quotient fits 8 bits, so the top bits start below the divisor
                    r_rem <= w_dvd[2*PIX_W:PIX_W];
                    r_dlo <= w_dvd[PIX_W-1:0];
                    r_dvs <= {w_den, 1'b0};
                    r_cnt <= CNT_W'(PIX_W - 1);
                end
                OP_DIV: begin
                    r_rem  <= w_qbit ? w_sub[PIX_W:0] : w_shift[PIX_W:0];
                    r_dlo  <= {r_dlo[PIX_W-2:0], 1'b0};
                    r_quot <= {r_quot[PIX_W-2:0], w_qbit};
                    r_cnt  <= r_cnt - 1'b1;
                end
                default: begin
                end
            endcase
            if (i_ctrl.op == OP_PUSH && w_out_free) begin
                r_out_vld  <= 1'b1;
                r_out_pix  <= r_quot;
                r_out_last <= r_last;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

[hdl/linear_contrast_stretch_unit.sv]
// Steps: clear/measure/unused kind run fetch, dispatch and the kind's step; stretch runs
// fetch, dispatch, load, bypass check, 8 restoring-divider steps and push to the output
// register, and goes from bypass check straight to push when the pixel skips the divider
// (flat or empty statistics, pixel clamped to 0 or 255).
// Throughput: one item at a time; the push step waits while the output register is held.
// Reset (sync, active low): statistics min=255 max=0, output empty, program at fetch.
module linear_contrast_stretch_unit
    import lcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [PIX_W-1:0]  i_s_tdata,   // [7:0] pixel
    input  logic [KIND_W-1:0] i_s_tuser,   // [1:0] kind
    input  logic              i_s_tlast,   // last
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [PIX_W-1:0]  o_m_tdata,   // [7:0] stretched
    output logic              o_m_tlast    // last_out
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    assign o_s_tready = w_ctrl.in_rdy;

    lcs_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    lcs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_s_tvalid  (i_s_tvalid),
        .i_pixel     (i_s_tdata),
        .i_kind      (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_m_tready  (i_m_tready),
        .o_stat      (w_stat),
        .o_m_tvalid  (o_m_tvalid),
        .o_stretched (o_m_tdata),
        .o_last_out  (o_m_tlast)
    );

    // one item in flight: a transfer in closes the input until the program returns
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again right after a transfer");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_PUSH && w_stat.out_free) |=> o_m_tvalid)
        else $error("pushed result missing from output register");

    a_valid_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_ctrl.op == OP_PUSH))
        else $error("output valid without a push step");

endmodule
